@@ hw/rtl/fwsd_pkg.sv @@
package fwsd_pkg;

  localparam int WHEEL_COUNT = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  localparam logic [7:0] LOW_COUNT_MAX = 8'd255;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PROTECT_ENABLE    = 3'd0,
    CFG_MIN_PULSES        = 3'd1,
    CFG_CONFIRM_WINDOWS   = 3'd2,
    CFG_GRACE_TIME        = 3'd3,
    CFG_CHECK_PERIOD      = 3'd4,
    CFG_COMMAND_THRESHOLD = 3'd5
  } cfg_reg_t;

  localparam logic        RST_PROTECT_ENABLE    = 1'b1;
  localparam logic [15:0] RST_MIN_PULSES        = 16'd5;
  localparam logic [7:0]  RST_CONFIRM_WINDOWS   = 8'd3;
  localparam logic [15:0] RST_GRACE_TIME        = 16'd1000;
  localparam logic [15:0] RST_CHECK_PERIOD      = 16'd100;
  localparam logic [14:0] RST_COMMAND_THRESHOLD = 15'd10;

  typedef enum logic {
    OP_UPDATE  = 1'b0,
    OP_RESTART = 1'b1
  } opcode_t;

  typedef struct packed {
    logic               opcode;
    logic        [31:0] now_time;
    logic signed [15:0] delta_front_left;
    logic signed [15:0] delta_rear_left;
    logic signed [15:0] delta_front_right;
    logic signed [15:0] delta_rear_right;
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
  } tick_t;

  typedef struct packed {
    logic stop_motors;
    logic window_checked;
  } result_t;

  function automatic logic [16:0] abs16(input logic signed [15:0] x);
    logic [16:0] ext;
    ext = {x[15], x};
    return x[15] ? (~ext + 17'd1) : ext;
  endfunction

endpackage

@@ hw/rtl/fwsd_stream_if.sv @@
interface fwsd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/four_wheel_stall_detector_unit.sv @@
// Channel   Dir  Payload    Beat
// tick      in   tick_t     valid & ready
// result    out  result_t   valid & ready
// cfg       in   16b data   cfg_we (index selects register)
//
// One result beat per tick beat. A tick accepted passes through the input
// register, then the result register. A new tick is taken every cycle unless
// the result side stalls; the input stage advances whenever the result
// register is empty or is drained in the same cycle.
// Synchronous reset clears state and loads the register defaults.
module four_wheel_stall_detector_unit
  import fwsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  fwsd_stream_if.sink            tick,
  fwsd_stream_if.source          result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic        protect_enable;
  logic [15:0] min_pulses;
  logic [7:0]  confirm_windows;
  logic [15:0] grace_time;
  logic [15:0] check_period;
  logic [14:0] command_threshold;

  logic        s1_valid;
  tick_t       s1_tick;
  logic        s1_fire;
  logic        res_valid;
  result_t     res_data;
  result_t     res_data_next;

  logic [31:0] pulse_sums [WHEEL_COUNT];
  logic [31:0] pulse_sums_next [WHEEL_COUNT];
  logic [7:0]  low_counts [WHEEL_COUNT];
  logic [7:0]  low_counts_next [WHEEL_COUNT];
  logic [31:0] last_check_time;
  logic [31:0] last_check_time_next;
  logic [31:0] grace_start_time;
  logic [31:0] grace_start_time_next;
  logic        fault_latched;
  logic        fault_latched_next;

  logic signed [15:0] deltas [WHEEL_COUNT];

  assign s1_fire        = s1_valid && (!res_valid || result.ready);
  assign tick.ready     = !s1_valid || s1_fire;
  assign result.valid   = res_valid;
  assign result.payload = res_data;

  assign deltas[0] = s1_tick.delta_front_left;
  assign deltas[1] = s1_tick.delta_rear_left;
  assign deltas[2] = s1_tick.delta_front_right;
  assign deltas[3] = s1_tick.delta_rear_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      protect_enable    <= RST_PROTECT_ENABLE;
      min_pulses        <= RST_MIN_PULSES;
      confirm_windows   <= RST_CONFIRM_WINDOWS;
      grace_time        <= RST_GRACE_TIME;
      check_period      <= RST_CHECK_PERIOD;
      command_threshold <= RST_COMMAND_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PROTECT_ENABLE:    protect_enable    <= cfg_data[0];
        CFG_MIN_PULSES:        min_pulses        <= cfg_data;
        CFG_CONFIRM_WINDOWS:   confirm_windows   <= cfg_data[7:0];
        CFG_GRACE_TIME:        grace_time        <= cfg_data;
        CFG_CHECK_PERIOD:      check_period      <= cfg_data;
        CFG_COMMAND_THRESHOLD: command_threshold <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      s1_tick <= tick.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_data <= res_data_next;
    end
  end

  always_comb begin
    logic [31:0] acc;
    logic        left_move;
    logic        right_move;
    logic        move;
    logic        stalled;

    for (int w = 0; w < WHEEL_COUNT; w++) begin
      pulse_sums_next[w] = pulse_sums[w];
      low_counts_next[w] = low_counts[w];
    end
    last_check_time_next  = last_check_time;
    grace_start_time_next = grace_start_time;
    fault_latched_next    = fault_latched;
    res_data_next         = '0;
    stalled               = 1'b0;
    acc                   = '0;
    move                  = 1'b0;
    left_move  = abs16(s1_tick.left_drive)  >= {2'b00, command_threshold};
    right_move = abs16(s1_tick.right_drive) >= {2'b00, command_threshold};

    if (s1_tick.opcode == OP_RESTART) begin
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        pulse_sums_next[w] = '0;
        low_counts_next[w] = '0;
      end
      last_check_time_next  = s1_tick.now_time;
      grace_start_time_next = s1_tick.now_time;
      fault_latched_next    = 1'b0;
    end else if (!protect_enable) begin
      res_data_next = '0;
    end else if (fault_latched) begin
      res_data_next.stop_motors = 1'b1;
    end else if ((s1_tick.now_time - grace_start_time) < {16'd0, grace_time}) begin
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        pulse_sums_next[w] = '0;
        low_counts_next[w] = '0;
      end
      last_check_time_next = s1_tick.now_time;
    end else if ((s1_tick.now_time - last_check_time) < {16'd0, check_period}) begin
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        pulse_sums_next[w] = pulse_sums[w] + {15'd0, abs16(deltas[w])};
      end
    end else begin
      last_check_time_next         = s1_tick.now_time;
      res_data_next.window_checked = 1'b1;
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        acc  = pulse_sums[w] + {15'd0, abs16(deltas[w])};
        move = (w < WHEEL_COUNT / 2) ? left_move : right_move;
        pulse_sums_next[w] = '0;
        if (!move) begin
          low_counts_next[w] = '0;
        end else begin
          if (acc < {16'd0, min_pulses}) begin
            if (low_counts[w] != LOW_COUNT_MAX) begin
              low_counts_next[w] = low_counts[w] + 8'd1;
            end
          end else begin
            low_counts_next[w] = '0;
          end
          if (low_counts_next[w] >= confirm_windows) begin
            stalled = 1'b1;
          end
        end
      end
      if (stalled) begin
        fault_latched_next        = 1'b1;
        res_data_next.stop_motors = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        pulse_sums[w] <= '0;
        low_counts[w] <= '0;
      end
      last_check_time  <= '0;
      grace_start_time <= '0;
      fault_latched    <= 1'b0;
    end else if (s1_fire) begin
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        pulse_sums[w] <= pulse_sums_next[w];
        low_counts[w] <= low_counts_next[w];
      end
      last_check_time  <= last_check_time_next;
      grace_start_time <= grace_start_time_next;
      fault_latched    <= fault_latched_next;
    end
  end

endmodule

@@ sim/tb_four_wheel_stall_detector_unit.sv @@
`timescale 1ns / 1ps

module tb_four_wheel_stall_detector_unit;
  import fwsd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  class stall_tracker;
    bit        protect_on;
    bit [15:0] min_pulses;
    bit [7:0]  confirm_cnt;
    bit [15:0] grace_ms;
    bit [15:0] period_ms;
    bit [14:0] drive_thr;
    bit [31:0] pulse_sum [WHEEL_COUNT];
    bit [7:0]  low_windows [WHEEL_COUNT];
    bit [31:0] last_check;
    bit [31:0] grace_start;
    bit        fault;
    result_t   pending_results [$];
    int        errors;

    function new();
      protect_on  = RST_PROTECT_ENABLE;
      min_pulses  = RST_MIN_PULSES;
      confirm_cnt = RST_CONFIRM_WINDOWS;
      grace_ms    = RST_GRACE_TIME;
      period_ms   = RST_CHECK_PERIOD;
      drive_thr   = RST_COMMAND_THRESHOLD;
      clear_history();
      last_check  = '0;
      grace_start = '0;
      fault       = 1'b0;
      errors      = 0;
    endfunction

    function void clear_history();
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        pulse_sum[w]   = '0;
        low_windows[w] = '0;
      end
    endfunction

    function void set_reg(cfg_reg_t idx, logic [15:0] d);
      case (idx)
        CFG_PROTECT_ENABLE:    protect_on  = d[0];
        CFG_MIN_PULSES:        min_pulses  = d;
        CFG_CONFIRM_WINDOWS:   confirm_cnt = d[7:0];
        CFG_GRACE_TIME:        grace_ms    = d;
        CFG_CHECK_PERIOD:      period_ms   = d;
        CFG_COMMAND_THRESHOLD: drive_thr   = d[14:0];
        default: ;
      endcase
    endfunction

    function bit [16:0] magnitude(logic [15:0] x);
      return x[15] ? (17'h10000 - {1'b0, x}) : {1'b0, x};
    endfunction

    function bit judge_wheel(int w, bit move);
      if (!move) begin
        pulse_sum[w]   = '0;
        low_windows[w] = '0;
        return 1'b0;
      end
      if (pulse_sum[w] < min_pulses) begin
        if (low_windows[w] < LOW_COUNT_MAX) low_windows[w]++;
      end else begin
        low_windows[w] = '0;
      end
      pulse_sum[w] = '0;
      return low_windows[w] >= confirm_cnt;
    endfunction

    function void take_tick(tick_t t);
      result_t   r;
      bit [31:0] since;
      bit        left_move;
      bit        right_move;
      bit        stalled;
      r = '0;
      stalled = 1'b0;
      if (t.opcode == OP_RESTART) begin
        clear_history();
        last_check  = t.now_time;
        grace_start = t.now_time;
        fault       = 1'b0;
      end else if (!protect_on) begin
        r = '0;
      end else if (fault) begin
        r.stop_motors = 1'b1;
      end else begin
        since = t.now_time - grace_start;
        if (since < grace_ms) begin
          clear_history();
          last_check = t.now_time;
        end else begin
          pulse_sum[0] += magnitude(t.delta_front_left);
          pulse_sum[1] += magnitude(t.delta_rear_left);
          pulse_sum[2] += magnitude(t.delta_front_right);
          pulse_sum[3] += magnitude(t.delta_rear_right);
          since = t.now_time - last_check;
          if (since >= period_ms) begin
            last_check = t.now_time;
            r.window_checked = 1'b1;
            left_move  = magnitude(t.left_drive) >= drive_thr;
            right_move = magnitude(t.right_drive) >= drive_thr;
            if (judge_wheel(0, left_move)) stalled = 1'b1;
            if (judge_wheel(1, left_move)) stalled = 1'b1;
            if (judge_wheel(2, right_move)) stalled = 1'b1;
            if (judge_wheel(3, right_move)) stalled = 1'b1;
            if (stalled) begin
              fault = 1'b1;
              r.stop_motors = 1'b1;
            end
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: stop_motors=%0b window_checked=%0b",
                   got.stop_motors, got.window_checked);
        return;
      end
      want = pending_results.pop_front();
      if (got.stop_motors !== want.stop_motors ||
          got.window_checked !== want.window_checked) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected stop_motors=%0b window_checked=%0b, got %0b %0b",
                   want.stop_motors, want.window_checked,
                   got.stop_motors, got.window_checked);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  fwsd_stream_if #(.payload_t(tick_t))   tick_ch ();
  fwsd_stream_if #(.payload_t(result_t)) res_ch ();

  stall_tracker tracker = new();

  int          ticks_sent  = 0;
  int          cycle_count = 0;
  bit          gaps_on     = 1'b1;
  bit          hold_req    = 1'b0;
  int          hold_len    = 0;
  logic [31:0] now_ms;

  four_wheel_stall_detector_unit dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_four_wheel_stall_detector_unit NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (tick_ch.valid && tick_ch.ready) tracker.take_tick(tick_ch.payload);
      if (res_ch.valid && res_ch.ready) tracker.check_result(res_ch.payload);
    end
  end

  // result side: random stalls in bursts, plus one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic tick_t build_tick(opcode_t op, logic [31:0] now,
                                       logic [15:0] fl, logic [15:0] rl,
                                       logic [15:0] fr, logic [15:0] rr,
                                       logic [15:0] ld, logic [15:0] rd);
    tick_t t;
    t.opcode            = op;
    t.now_time          = now;
    t.delta_front_left  = fl;
    t.delta_rear_left   = rl;
    t.delta_front_right = fr;
    t.delta_rear_right  = rr;
    t.left_drive        = ld;
    t.right_drive       = rd;
    return t;
  endfunction

  // mostly around the low-pulse limit so windows go both ways
  function automatic logic [15:0] pick_pulses();
    int          minp;
    int          mag;
    logic [15:0] v;
    minp = tracker.min_pulses;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: mag = $urandom_range(0, minp / 2 + 1);
      5, 6:          mag = $urandom_range(0, (minp + 2 > 32768) ? 32768 : minp + 2);
      7:             mag = $urandom_range(0, 1) ? 32768 : 32767;
      default:       return 16'($urandom);
    endcase
    v = mag[15:0];
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic logic [15:0] pick_drive();
    int          thr;
    int          mag;
    logic [15:0] v;
    thr = tracker.drive_thr;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: mag = $urandom_range(thr, 32768);
      6:                mag = (thr > 0 && $urandom_range(0, 1)) ? thr - 1 : thr;
      7:                mag = 32768;
      8:                mag = $urandom_range(0, thr);
      default:          return 16'($urandom);
    endcase
    v = mag[15:0];
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic send_tick(input tick_t t);
    tick_ch.valid   <= 1'b1;
    tick_ch.payload <= t;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    ticks_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_results();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_results.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    tracker.set_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic load_limits(input logic [15:0] pe, input logic [15:0] minp,
                             input logic [15:0] conf, input logic [15:0] grace,
                             input logic [15:0] period, input logic [15:0] thr);
    wait_results();
    write_reg(CFG_PROTECT_ENABLE, pe);
    write_reg(CFG_MIN_PULSES, minp);
    write_reg(CFG_CONFIRM_WINDOWS, conf);
    write_reg(CFG_GRACE_TIME, grace);
    write_reg(CFG_CHECK_PERIOD, period);
    write_reg(CFG_COMMAND_THRESHOLD, thr);
    cfg_we <= 1'b0;
  endtask

  // restart, then a run of updates with time moving at about the window rate
  task automatic run_episode(input int n, input bit noise);
    int      g;
    int      p;
    int      r;
    opcode_t op;
    g = tracker.grace_ms;
    p = tracker.period_ms;
    now_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2 * g + 200)
                                         : $urandom;
    send_tick(build_tick(OP_RESTART, now_ms, pick_pulses(), pick_pulses(),
                         pick_pulses(), pick_pulses(), pick_drive(), pick_drive()));
    for (int k = 1; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (noise && r < 3) now_ms += $urandom;
      else if (r < 10)    now_ms += $urandom_range(0, g + p + 1);
      else                now_ms += $urandom_range(0, p + p / 2 + 1);
      op = (noise && $urandom_range(0, 39) == 0) ? OP_RESTART : OP_UPDATE;
      send_tick(build_tick(op, now_ms, pick_pulses(), pick_pulses(),
                           pick_pulses(), pick_pulses(), pick_drive(), pick_drive()));
    end
  endtask

  initial begin
    logic [31:0] t0;
    logic [31:0] t1;
    int          ph;
    int          quota;
    rst             <= 1'b1;
    tick_ch.valid   <= 1'b0;
    tick_ch.payload <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_PROTECT_ENABLE;
    cfg_data        <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults: grace 1000, window 100, min 5, confirm 3, drive 10
    t0 = 32'hFFFF_FF00;
    t1 = t0 + 32'd1000;
    send_tick(build_tick(OP_UPDATE, 32'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'd100, 16'd100));
    send_tick(build_tick(OP_RESTART, t0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    send_tick(build_tick(OP_UPDATE, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0,
                         16'h8000, 16'h7FFF));
    // grace ends exactly here across the time wrap; right side below command
    send_tick(build_tick(OP_UPDATE, t1, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0,
                         16'd10, 16'hFFF7));
    send_tick(build_tick(OP_UPDATE, t1 + 32'd99, 16'd1, 16'h0, 16'h0, 16'h0,
                         16'd10, 16'hFFF7));
    send_tick(build_tick(OP_UPDATE, t1 + 32'd100, 16'h0, 16'h0, 16'h0, 16'h0,
                         16'h8000, 16'hFFF6));
    send_tick(build_tick(OP_UPDATE, t1 + 32'd200, 16'd4, 16'hFFFC, 16'd5, 16'hFFFB,
                         16'h7FFF, 16'h8001));
    send_tick(build_tick(OP_UPDATE, t1 + 32'd300, 16'h0, 16'h0, 16'h0, 16'h0,
                         16'd10, 16'hFFF7));
    send_tick(build_tick(OP_UPDATE, t1 + 32'd400, 16'h0, 16'h0, 16'h0, 16'h0,
                         16'd100, 16'd100));
    send_tick(build_tick(OP_RESTART, t1 + 32'd400, 16'h0, 16'h0, 16'h0, 16'h0,
                         16'h0, 16'h0));
    send_tick(build_tick(OP_UPDATE, t1 + 32'd1399, 16'h0, 16'h0, 16'h0, 16'h0,
                         16'd100, 16'd100));

    // protection off: updates do nothing, restart still acts
    load_limits(16'd0, 16'd5, 16'd3, 16'd1000, 16'd100, 16'd10);
    send_tick(build_tick(OP_UPDATE, t1 + 32'd5000, 16'h0, 16'h0, 16'h0, 16'h0,
                         16'd100, 16'd100));
    send_tick(build_tick(OP_RESTART, 32'd7, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));

    // zero confirm, window, grace and command level: first tick trips
    load_limits(16'd1, 16'd5, 16'd0, 16'd0, 16'd0, 16'd0);
    send_tick(build_tick(OP_UPDATE, 32'd7, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                         16'h0, 16'h0));
    send_tick(build_tick(OP_RESTART, 32'd8, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    send_tick(build_tick(OP_UPDATE, 32'd8, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));

    for (ph = 0; ticks_sent < 1100; ph++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case (ph)
        0: load_limits(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        1: load_limits(16'd1, 16'hFFFF, 16'd255, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        2: load_limits(16'd1, 16'hFFFF, 16'd255, 16'd0, 16'd0, 16'd0);
        3: load_limits(16'd0, 16'($urandom_range(0, 40)), 16'($urandom_range(0, 6)),
                       16'($urandom_range(0, 300)), 16'($urandom_range(0, 60)),
                       16'($urandom_range(0, 200)));
        default:
          if ($urandom_range(0, 4) == 0)
            load_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
          else
            load_limits(16'd1, 16'($urandom_range(0, 40)), 16'($urandom_range(0, 6)),
                        16'($urandom_range(0, 300)), 16'($urandom_range(0, 60)),
                        16'($urandom_range(0, 200)));
      endcase
      if (ph == 4) begin
        hold_len = 80;
        hold_req = 1'b1;
      end
      if (ph == 2) begin
        // every tick closes a window: count climbs to the 255 ceiling
        run_episode(280, 1'b0);
      end else begin
        quota = ticks_sent + $urandom_range(60, 120);
        while (ticks_sent < quota) run_episode($urandom_range(6, 40), 1'b1);
      end
    end

    gaps_on = 1'b0;
    load_limits(16'd1, 16'd5, 16'd3, 16'd1000, 16'd100, 16'd10);
    quota = ticks_sent + 150;
    while (ticks_sent < quota) run_episode($urandom_range(10, 40), 1'b1);

    wait_results();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0)
      $display("tb_four_wheel_stall_detector_unit OK");
    else
      $display("tb_four_wheel_stall_detector_unit NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/fwsd_pkg.sv
hw/rtl/fwsd_stream_if.sv
hw/rtl/four_wheel_stall_detector_unit.sv
sim/tb_four_wheel_stall_detector_unit.sv
